### rtl/fcr_pkg.sv
// Shared types, codes and constants of the framed command responder.
`timescale 1ns / 1ps
package fcr_pkg;

  // Frame bytes and message codes.
  localparam logic [7:0] HDR_BYTE    = 8'hAB;
  localparam logic [7:0] SYS_MSG     = 8'h0A;
  localparam logic [7:0] SYS_VERSION = 8'h01;
  localparam logic [7:0] SYS_CHKSUM  = 8'h02;
  localparam logic [7:0] ACK_BYTE    = 8'hAC;
  localparam logic [7:0] ERR_MSG     = 8'h0F;

  // Error codes carried in an error response.
  localparam logic [7:0] ERR_HEADER  = 8'h01;
  localparam logic [7:0] ERR_LENGTH  = 8'h02;
  localparam logic [7:0] ERR_CHKSUM  = 8'h03;
  localparam logic [7:0] ERR_UNKNOWN = 8'h04;
  localparam logic [7:0] ERR_RANGE   = 8'h05;

  // Response lengths on the wire (content count + 2).
  localparam logic [7:0] LEN_VERSION = 8'd7;
  localparam logic [7:0] LEN_ACK     = 8'd5;
  localparam logic [7:0] LEN_ERROR   = 8'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_MAJOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_MINOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_BUILD = 2'd2;

  // Defaults for the top-level parameters.
  localparam int MAX_LENGTH_DEFAULT  = 20;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Kinds of response the front hands to the back.
  typedef enum logic [1:0] {
    RESP_VERSION,
    RESP_ACK,
    RESP_ERROR
  } resp_kind_t;

  // One queued response request.
  typedef struct packed {
    resp_kind_t  kind;
    logic [7:0]  code;
    logic        chk;
  } resp_t;

  // Request from the front into the queue.
  typedef struct packed {
    logic  valid;
    resp_t resp;
  } push_t;

  // Queue status seen by the back.
  typedef struct packed {
    logic  empty;
    resp_t head;
  } queue_head_t;

endpackage

### rtl/fcr_if.sv
// Valid/ready channel interfaces for received and transmitted bytes.
`timescale 1ns / 1ps
interface fcr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface fcr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;

  modport source(output valid, output tx_byte, output frame_end, input ready);
  modport sink(input valid, input tx_byte, input frame_end, output ready);
endinterface

### rtl/fcr_front.sv
// Frame parser: tracks the frame phase, checks length and checksum, decodes commands.
`timescale 1ns / 1ps
module fcr_front #(
  parameter int MAX_LENGTH = fcr_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_ready,
  input  logic          queue_full,
  output fcr_pkg::push_t push
);

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_LENGTH);

  // Frame phase codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_SUMHI   = 3'd3;
  localparam logic [2:0] PH_SUMLO   = 3'd4;

  logic [2:0]       phase, phase_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] byte_position, byte_position_next;
  logic [LEN_W-1:0] pos_inc;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       sum_high, sum_high_next;
  logic [7:0]       lead [3];
  logic [7:0]       lead_next [3];
  logic             checksum_on, checksum_on_next;
  logic [1:0]       lead_idx;
  logic [15:0]      want_sum;
  logic             accept;

  // A byte is taken whenever the queue can hold any response it may cause.
  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign pos_inc  = byte_position + LEN_W'(1);
  assign lead_idx = 2'(byte_position - LEN_W'(2));
  assign want_sum = checksum_on ? running_sum : 16'd0;

  // Next-state and response decode for one accepted byte.
  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    sum_high_next      = sum_high;
    lead_next          = lead;
    checksum_on_next   = checksum_on;
    push.valid         = 1'b0;
    push.resp.kind     = fcr_pkg::RESP_ERROR;
    push.resp.code     = fcr_pkg::ERR_HEADER;
    push.resp.chk      = checksum_on;
    if (accept) begin
      unique case (phase)
        PH_LEN: begin
          if (in_byte > MAX_LEN_BYTE || in_byte < 8'd2) begin
            phase_next     = PH_IDLE;
            lead_next      = '{default: 8'd0};
            push.valid     = 1'b1;
            push.resp.code = fcr_pkg::ERR_LENGTH;
          end else begin
            frame_length_next  = in_byte[LEN_W-1:0];
            byte_position_next = LEN_W'(2);
            running_sum_next   = 16'd0;
            phase_next         = (in_byte == 8'd2) ? PH_SUMHI : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (byte_position < LEN_W'(5)) begin
            lead_next[lead_idx] = in_byte;
          end
          running_sum_next   = running_sum + {8'd0, in_byte};
          byte_position_next = pos_inc;
          if (pos_inc >= frame_length) begin
            phase_next = PH_SUMHI;
          end
        end
        PH_SUMHI: begin
          sum_high_next = in_byte;
          phase_next    = PH_SUMLO;
        end
        PH_SUMLO: begin
          phase_next = PH_IDLE;
          lead_next  = '{default: 8'd0};
          push.valid = 1'b1;
          if ({sum_high, in_byte} != want_sum) begin
            push.resp.code = fcr_pkg::ERR_CHKSUM;
          end else if (lead[0] != fcr_pkg::SYS_MSG) begin
            push.resp.code = fcr_pkg::ERR_UNKNOWN;
          end else if (lead[1] == fcr_pkg::SYS_VERSION) begin
            push.resp.kind = fcr_pkg::RESP_VERSION;
          end else if (lead[1] == fcr_pkg::SYS_CHKSUM) begin
            if (lead[2] > 8'd1) begin
              push.resp.code = fcr_pkg::ERR_RANGE;
            end else begin
              // The acknowledge already follows the new checksum setting.
              checksum_on_next = lead[2][0];
              push.resp.kind   = fcr_pkg::RESP_ACK;
              push.resp.chk    = lead[2][0];
            end
          end else begin
            push.resp.code = fcr_pkg::ERR_UNKNOWN;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (in_byte != fcr_pkg::HDR_BYTE) begin
            push.valid     = 1'b1;
            push.resp.code = fcr_pkg::ERR_HEADER;
          end else begin
            phase_next = PH_LEN;
          end
        end
      endcase
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_length  <= '0;
      byte_position <= '0;
      running_sum   <= 16'd0;
      sum_high      <= 8'd0;
      lead          <= '{default: 8'd0};
      checksum_on   <= 1'b1;
    end else begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      sum_high      <= sum_high_next;
      lead          <= lead_next;
      checksum_on   <= checksum_on_next;
    end
  end

endmodule

### rtl/fcr_queue.sv
// Small first-in first-out queue of response requests between front and back.
`timescale 1ns / 1ps
module fcr_queue #(
  parameter int DEPTH = fcr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fcr_pkg::push_t       push,
  output logic                 full,
  input  logic                 pop,
  output fcr_pkg::queue_head_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  fcr_pkg::resp_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full        = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign status.head  = slots[rd_ptr];
  assign do_push     = push.valid && !full;
  assign do_pop      = pop && !status.empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.resp;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/fcr_back.sv
// Response serializer: expands a queued request into framed bytes behind an output register.
`timescale 1ns / 1ps
module fcr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fcr_pkg::queue_head_t status,
  output logic                 pop,
  input  logic [7:0]           version_major,
  input  logic [7:0]           version_minor,
  input  logic [7:0]           version_build,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_end
);

  logic                active;
  fcr_pkg::resp_kind_t kind;
  logic [7:0]          code;
  logic [15:0]         sum;
  logic [3:0]          idx;
  logic [7:0]          wire_len;
  logic [3:0]          last_idx;
  logic [2:0]          content_idx;
  logic [7:0]          content_byte;
  logic [7:0]          cur_byte;
  logic                load;
  logic [15:0]         raw_sum;

  // Current response: wire length, last byte index and byte at idx.
  always_comb begin
    unique case (kind)
      fcr_pkg::RESP_VERSION: wire_len = fcr_pkg::LEN_VERSION;
      fcr_pkg::RESP_ACK:     wire_len = fcr_pkg::LEN_ACK;
      default:               wire_len = fcr_pkg::LEN_ERROR;
    endcase
    last_idx    = 4'(wire_len + 8'd1);
    content_idx = 3'(idx - 4'd2);
    content_byte = fcr_pkg::ERR_MSG;
    unique case (kind)
      fcr_pkg::RESP_VERSION: begin
        unique case (content_idx)
          3'd0:    content_byte = fcr_pkg::SYS_MSG;
          3'd1:    content_byte = fcr_pkg::SYS_VERSION;
          3'd2:    content_byte = version_major;
          3'd3:    content_byte = version_minor;
          default: content_byte = version_build;
        endcase
      end
      fcr_pkg::RESP_ACK: begin
        unique case (content_idx)
          3'd0:    content_byte = fcr_pkg::SYS_MSG;
          3'd1:    content_byte = fcr_pkg::SYS_CHKSUM;
          default: content_byte = fcr_pkg::ACK_BYTE;
        endcase
      end
      default: begin
        content_byte = (content_idx == 3'd0) ? fcr_pkg::ERR_MSG : code;
      end
    endcase
    priority if (idx == 4'd0) begin
      cur_byte = fcr_pkg::HDR_BYTE;
    end else if (idx == 4'd1) begin
      cur_byte = wire_len;
    end else if (idx == last_idx) begin
      cur_byte = sum[7:0];
    end else if (idx == last_idx - 4'd1) begin
      cur_byte = sum[15:8];
    end else begin
      cur_byte = content_byte;
    end
  end

  // Checksum of the content of the request at the queue head.
  always_comb begin
    unique case (status.head.kind)
      fcr_pkg::RESP_VERSION: begin
        raw_sum = 16'(fcr_pkg::SYS_MSG) + 16'(fcr_pkg::SYS_VERSION)
                + {8'd0, version_major} + {8'd0, version_minor}
                + {8'd0, version_build};
      end
      fcr_pkg::RESP_ACK: begin
        raw_sum = 16'(fcr_pkg::SYS_MSG) + 16'(fcr_pkg::SYS_CHKSUM)
                + 16'(fcr_pkg::ACK_BYTE);
      end
      default: begin
        raw_sum = 16'(fcr_pkg::ERR_MSG) + {8'd0, status.head.code};
      end
    endcase
  end

  assign pop  = !active && !status.empty;
  assign load = active && (!out_valid || out_ready);

  // Request register and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 4'd0;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= 4'd0;
    end else if (load) begin
      idx <= idx + 4'd1;
      if (idx == last_idx) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= status.head.kind;
      code <= status.head.code;
      sum  <= status.head.chk ? raw_sum : 16'd0;
    end
  end

  // Output register: holds a byte until it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= cur_byte;
      out_end  <= (idx == last_idx);
    end
  end

endmodule

### rtl/framed_command_responder.sv
// Top level of the framed command responder: configuration, front, queue and back.
//
//   channel | dir | payload             | transfer when
//   --------+-----+---------------------+----------------------
//   rx      | in  | rx_byte[7:0]        | rx.valid && rx.ready
//   tx      | out | tx_byte, frame_end  | tx.valid && tx.ready
//   cfg     | in  | cfg_index, cfg_data | cfg_we
//
// One received byte is taken per cycle while the response queue has room.
// A response leaves as 6, 7 or 9 bytes at one per cycle while tx is ready, once
// fetched from the queue; the serializer sets the sustained response rate.
// Reset is synchronous; it clears the frame phase and restores checksums on.
// Stalled tx holds its byte in the output register; rx runs till the queue fills.
`timescale 1ns / 1ps
module framed_command_responder #(
  parameter int MAX_LENGTH  = fcr_pkg::MAX_LENGTH_DEFAULT,
  parameter int QUEUE_DEPTH = fcr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  fcr_rx_if.sink                        rx,
  fcr_tx_if.source                      tx,
  input  logic                          cfg_we,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  logic [7:0]           version_major;
  logic [7:0]           version_minor;
  logic [7:0]           version_build;
  fcr_pkg::push_t       push;
  fcr_pkg::queue_head_t status;
  logic                 queue_full;
  logic                 pop;

  // Version registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      version_major <= 8'd0;
      version_minor <= 8'd0;
      version_build <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcr_pkg::REG_VERSION_MAJOR: version_major <= cfg_data;
        fcr_pkg::REG_VERSION_MINOR: version_minor <= cfg_data;
        fcr_pkg::REG_VERSION_BUILD: version_build <= cfg_data;
        default: ;
      endcase
    end
  end

  fcr_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_byte    (rx.rx_byte),
    .in_ready   (rx.ready),
    .queue_full (queue_full),
    .push       (push)
  );

  fcr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (queue_full),
    .pop    (pop),
    .status (status)
  );

  fcr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .status        (status),
    .pop           (pop),
    .version_major (version_major),
    .version_minor (version_minor),
    .version_build (version_build),
    .out_valid     (tx.valid),
    .out_ready     (tx.ready),
    .out_byte      (tx.tx_byte),
    .out_end       (tx.frame_end)
  );

endmodule

### rtl/fcr_checker.sv
// Port-level checks of the framed command responder, bound to the top level.
`timescale 1ns / 1ps
module fcr_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_byte,
  input logic       frame_end
);

  logic tx_xfer;
  logic expect_hdr;
  logic expect_len;

  assign tx_xfer = tx_valid && tx_ready;

  // Track where the next transferred byte sits in a response frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_hdr <= 1'b1;
      expect_len <= 1'b0;
    end else if (tx_xfer) begin
      expect_hdr <= frame_end;
      expect_len <= expect_hdr;
    end
  end

  // A response byte waiting for the sink stays put.
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(frame_end))
    else $error("tx byte changed while stalled");

  // Every response frame opens with the header byte.
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    tx_xfer && expect_hdr |-> tx_byte == fcr_pkg::HDR_BYTE && !frame_end)
    else $error("response frame does not start with header");

  // The length byte names one of the three response sizes.
  a_len: assert property (@(posedge clk) disable iff (rst)
    tx_xfer && expect_len |->
      tx_byte == fcr_pkg::LEN_VERSION || tx_byte == fcr_pkg::LEN_ACK ||
      tx_byte == fcr_pkg::LEN_ERROR)
    else $error("response length byte out of set");

  // Reset leaves no response pending and the receiver open.
  a_reset: assert property (@(posedge clk)
    rst |=> !tx_valid && rx_ready)
    else $error("state after reset not clean");

endmodule

bind framed_command_responder fcr_checker u_fcr_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .tx_valid  (tx.valid),
  .tx_ready  (tx.ready),
  .tx_byte   (tx.tx_byte),
  .frame_end (tx.frame_end)
);

### verif/framed_command_responder_tb.sv
// Testbench for the framed command responder: byte-level prediction and response checking.
`timescale 1ns / 1ps
module framed_command_responder_tb;

  localparam int FRAME_MAX     = fcr_pkg::MAX_LENGTH_DEFAULT;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_BYTES   = 35;

  // Index past the last version register; writes to it must be ignored.
  localparam logic [fcr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Receive-side frame tracking states of the predictor.
  typedef enum logic [2:0] {
    WAIT_HDR,
    WAIT_LEN,
    IN_PAYLOAD,
    SUM_HI,
    SUM_LO
  } rx_phase_t;

  // One expected byte of a response frame.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } tx_beat_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;

  fcr_rx_if rx_ch();
  fcr_tx_if tx_ch();

  framed_command_responder dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .tx        (tx_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state and configuration copy.
  rx_phase_t  rx_phase;
  int         frame_len;
  int         frame_pos;
  logic [15:0] payload_sum;
  logic [7:0] sum_high;
  logic [7:0] lead_bytes [3];
  logic       chk_on;
  logic [7:0] ver_major;
  logic [7:0] ver_minor;
  logic [7:0] ver_build;

  tx_beat_t pending_tx [$];

  int err_count;
  int cycle_count;
  int rx_sent;
  int send_idle_pct;
  int recv_stall_pct;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("framed_command_responder_tb: done, errors");
      $finish;
    end
  end

  // Receiver back-pressure on the response channel.
  always @(posedge clk) begin
    tx_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic log_error(input string msg);
    if (err_count < MAX_REPORTS) $display("%s", msg);
    err_count++;
  endtask

  // Compare each response transfer against the oldest expected byte.
  always @(posedge clk) begin
    tx_beat_t want;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (pending_tx.size() == 0) begin
        log_error($sformatf("unexpected response byte %02h frame_end %0b",
                            tx_ch.tx_byte, tx_ch.frame_end));
      end else begin
        want = pending_tx.pop_front();
        if (tx_ch.tx_byte !== want.tx_byte)
          log_error($sformatf("tx_byte mismatch: expected %02h, got %02h",
                              want.tx_byte, tx_ch.tx_byte));
        if (tx_ch.frame_end !== want.frame_end)
          log_error($sformatf("frame_end mismatch: expected %0b, got %0b (byte %02h)",
                              want.frame_end, tx_ch.frame_end, tx_ch.tx_byte));
      end
    end
  end

  // Queue a framed response: header, length, content, then its 16-bit sum.
  task automatic queue_response(input logic [7:0] content[$]);
    logic [15:0] sum;
    sum = 16'h0000;
    foreach (content[i]) sum = sum + 16'(content[i]);
    if (!chk_on) sum = 16'h0000;
    pending_tx.push_back('{fcr_pkg::HDR_BYTE, 1'b0});
    pending_tx.push_back('{8'(content.size() + 2), 1'b0});
    foreach (content[i]) pending_tx.push_back('{content[i], 1'b0});
    pending_tx.push_back('{sum[15:8], 1'b0});
    pending_tx.push_back('{sum[7:0], 1'b1});
  endtask

  task automatic queue_error(input logic [7:0] code);
    logic [7:0] content[$];
    content = '{fcr_pkg::ERR_MSG, code};
    queue_response(content);
  endtask

  // Decode the first three payload bytes of a frame with a good checksum.
  task automatic answer_command();
    logic [7:0] content[$];
    if (lead_bytes[0] != fcr_pkg::SYS_MSG) begin
      queue_error(fcr_pkg::ERR_UNKNOWN);
    end else if (lead_bytes[1] == fcr_pkg::SYS_VERSION) begin
      content = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION, ver_major, ver_minor, ver_build};
      queue_response(content);
    end else if (lead_bytes[1] == fcr_pkg::SYS_CHKSUM) begin
      if (lead_bytes[2] > 8'd1) begin
        queue_error(fcr_pkg::ERR_RANGE);
      end else begin
        // The acknowledge already follows the new checksum setting.
        chk_on = lead_bytes[2][0];
        content = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_CHKSUM, fcr_pkg::ACK_BYTE};
        queue_response(content);
      end
    end else begin
      queue_error(fcr_pkg::ERR_UNKNOWN);
    end
  endtask

  // Advance the frame tracker by one accepted byte.
  task automatic track_rx_byte(input logic [7:0] b);
    logic [15:0] got;
    logic [15:0] want;
    case (rx_phase)
      WAIT_LEN: begin
        if (b > FRAME_MAX || b < 2) begin
          rx_phase = WAIT_HDR;
          lead_bytes = '{default: 8'h00};
          queue_error(fcr_pkg::ERR_LENGTH);
        end else begin
          frame_len = b;
          frame_pos = 2;
          payload_sum = 16'h0000;
          rx_phase = (b == 8'd2) ? SUM_HI : IN_PAYLOAD;
        end
      end
      IN_PAYLOAD: begin
        if (frame_pos < 5) lead_bytes[frame_pos - 2] = b;
        payload_sum = payload_sum + 16'(b);
        frame_pos++;
        if (frame_pos >= frame_len) rx_phase = SUM_HI;
      end
      SUM_HI: begin
        sum_high = b;
        rx_phase = SUM_LO;
      end
      SUM_LO: begin
        got = {sum_high, b};
        want = chk_on ? payload_sum : 16'h0000;
        rx_phase = WAIT_HDR;
        if (got != want) queue_error(fcr_pkg::ERR_CHKSUM);
        else answer_command();
        lead_bytes = '{default: 8'h00};
      end
      default: begin
        rx_phase = WAIT_HDR;
        if (b != fcr_pkg::HDR_BYTE) queue_error(fcr_pkg::ERR_HEADER);
        else rx_phase = WAIT_LEN;
      end
    endcase
  endtask

  // Offer one byte, with random idle cycles first, and track it once transferred.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    track_rx_byte(b);
    rx_sent++;
  endtask

  // Send a whole frame; a nonzero sum_error corrupts the checksum.
  task automatic send_frame(input logic [7:0] body[$], input logic [15:0] sum_error);
    logic [15:0] sum;
    sum = 16'h0000;
    if (chk_on) foreach (body[i]) sum = sum + 16'(body[i]);
    sum = sum ^ sum_error;
    send_byte(fcr_pkg::HDR_BYTE);
    send_byte(8'(body.size() + 2));
    foreach (body[i]) send_byte(body[i]);
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endtask

  // Stop offering and let all outstanding responses drain.
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fcr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      fcr_pkg::REG_VERSION_MAJOR: ver_major = val;
      fcr_pkg::REG_VERSION_MINOR: ver_minor = val;
      fcr_pkg::REG_VERSION_BUILD: ver_build = val;
      default: ;
    endcase
  endtask

  // Load all version registers, plus a write to the unused index.
  task automatic load_version(input logic [7:0] major, input logic [7:0] minor,
                              input logic [7:0] build);
    write_reg(fcr_pkg::REG_VERSION_MAJOR, major);
    write_reg(fcr_pkg::REG_VERSION_MINOR, minor);
    write_reg(fcr_pkg::REG_VERSION_BUILD, build);
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Stray bytes, lengths out of range and the bytes that follow a rejected length.
  task automatic test_framing_errors();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(fcr_pkg::HDR_BYTE);
    send_byte(8'(FRAME_MAX + 1));
    send_byte(fcr_pkg::SYS_MSG);
    send_byte(fcr_pkg::HDR_BYTE);
    send_byte(8'h01);
  endtask

  // Query, unknown, short and bad-checksum command shapes under checksums on.
  task automatic test_commands();
    logic [7:0] body[$];
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION};
    send_frame(body, 16'h0000);
    body.delete();
    send_frame(body, 16'h0000);
    body = '{8'h0B, fcr_pkg::SYS_VERSION, 8'h00};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, 8'h03};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION, 8'h00, 8'h7F, 8'hFF};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION};
    send_frame(body, 16'h0001);
    // Longest legal frame.
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION};
    while (body.size() < FRAME_MAX - 2) body.push_back(8'hFF);
    send_frame(body, 16'h0000);
  endtask

  // Switching checksums off and on, range errors and a short switch command.
  task automatic test_checksum_mode();
    logic [7:0] body[$];
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_CHKSUM, 8'h00};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION};
    send_frame(body, 16'h0000);
    send_frame(body, 16'h8000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_CHKSUM, 8'h02};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_CHKSUM, 8'hFF};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_CHKSUM};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_CHKSUM, 8'h01};
    send_frame(body, 16'h0000);
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION};
    send_frame(body, 16'h0000);
  endtask

  // Version register settings at the extremes, each read back by a query.
  task automatic test_version_registers();
    logic [7:0] body[$];
    body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION};
    wait_idle();
    load_version(8'hFF, 8'hFF, 8'hFF);
    send_frame(body, 16'h0000);
    wait_idle();
    load_version(8'h00, 8'h80, 8'h01);
    send_frame(body, 16'h0000);
    wait_idle();
    load_version(8'($urandom), 8'($urandom), 8'($urandom));
    send_frame(body, 16'h0000);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic send_random_frame();
    logic [7:0]  body[$];
    logic [15:0] sum_error;
    int          kind;
    int          np;
    kind = $urandom_range(99);
    body.delete();
    if (kind < 40) begin
      body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_VERSION};
    end else if (kind < 70) begin
      body = '{fcr_pkg::SYS_MSG, fcr_pkg::SYS_CHKSUM,
               ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1))};
    end else if (kind < 88) begin
      body.push_back(($urandom_range(1) == 0) ? fcr_pkg::SYS_MSG : 8'($urandom));
    end else if (kind < 94) begin
      // Length out of range.
      send_byte(fcr_pkg::HDR_BYTE);
      send_byte(($urandom_range(1) == 0) ? 8'($urandom_range(1))
                                         : 8'($urandom_range(255, FRAME_MAX + 1)));
      return;
    end else begin
      send_byte(8'($urandom));
      return;
    end
    // Payload size: usually the command plus a short tail, sometimes anything legal.
    if ($urandom_range(9) == 0) np = $urandom_range(FRAME_MAX - 2);
    else np = body.size() + $urandom_range(2);
    while (body.size() < np) body.push_back(8'($urandom));
    while (body.size() > np) void'(body.pop_back());
    sum_error = ($urandom_range(7) == 0) ? 16'($urandom_range(65535, 1)) : 16'h0000;
    send_frame(body, sum_error);
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct);
    int start_count;
    wait_idle();
    load_version(8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count = rx_sent;
    while (rx_sent - start_count < PHASE_BYTES) send_random_frame();
  endtask

  // Test sequence.
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= 8'h00;
    rx_ch.valid    <= 1'b0;
    rx_ch.rx_byte  <= 8'h00;
    rx_sent        = 0;
    send_idle_pct  = 17;
    recv_stall_pct = 52;
    rx_phase       = WAIT_HDR;
    frame_len      = 0;
    frame_pos      = 0;
    payload_sum    = 16'h0000;
    sum_high       = 8'h00;
    lead_bytes     = '{default: 8'h00};
    chk_on         = 1'b1;
    ver_major      = 8'h00;
    ver_minor      = 8'h00;
    ver_build      = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_framing_errors();
    test_commands();
    test_checksum_mode();
    test_version_registers();
    test_random(17, 52);
    test_random(52, 17);
    test_random(0, 0);

    wait_idle();
    if (err_count == 0) begin
      $display("framed_command_responder_tb: done, clean");
    end else begin
      $display("framed_command_responder_tb: done, errors");
    end
    $finish;
  end

endmodule
